@@ rtl/pls_pkg.sv @@
// ============================================================================
// pls_pkg: shared types and codes for the positional list store
// Command and status codes, plus the packed input and result words.
// ============================================================================
`default_nettype none

package pls_pkg;

    // Command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_AT    = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [2:0] CMD_DEL_AT    = 3'd5;
    localparam logic [2:0] CMD_READ_ALL  = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] value;
        logic [7:0]  position;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] element;
        logic        has_element;
        logic [4:0]  entry_count;
        logic        last;
    } t_out_word;

endpackage

`default_nettype wire

@@ rtl/pls_ram.sv @@
// ============================================================================
// pls_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/pls_cursor.sv @@
// ============================================================================
// pls_cursor: shared slot cursor step and compare unit
// Steps the cursor up or down by one and compares cursor and stepped cursor
// against a bound.
// ============================================================================
`default_nettype none

module pls_cursor #(
    parameter int CW = 5
) (
    input  wire logic [CW-1:0] i_cur,
    input  wire logic [CW-1:0] i_bound,
    input  wire logic          i_up,
    output logic      [CW-1:0] o_nxt,
    output logic               o_hit_cur,
    output logic               o_hit_nxt
);

    always_comb begin
        o_nxt     = i_up ? (i_cur + CW'(1)) : (i_cur - CW'(1));
        o_hit_cur = (i_cur == i_bound);
        o_hit_nxt = (o_nxt == i_bound);
    end

endmodule

`default_nettype wire

@@ rtl/positional_list_store.sv @@
// ============================================================================
// positional_list_store: bounded ordered list with positional edits
// Keeps up to DEPTH words in list order in a RAM and edits them by moving
// entries one slot at a time under a small sequencer.
// ============================================================================
//
// The block holds an ordered list of up to DEPTH words in slots 0..fill-1 of
// a single-port-write RAM. Each input word carries a command: insert at the
// front, the back or a 1-based position, delete the front, the back or a
// position, or read out the whole list. Edits move every entry behind the
// edit point by one slot, one entry at a time (read the neighbor, then
// write it), through one shared cursor step/compare unit; the sequencer waits
// out the RAM's registered read before each write, and that sets the pace. An
// insert or delete moves its entries and then passes through the done state
// to its status word; a rejected command (bad position, full, empty) goes
// straight to the done state. Read-out emits one word per entry, last marked,
// or a single word with has_element low when the list is empty; a stall on
// the result channel stretches it. The input channel takes a new word only
// when the sequencer is idle, while the previous result may still sit in the
// output register. Position is checked before full or empty, so a positional
// delete on an empty list reports an invalid position. Unused command code 7
// changes nothing and returns one ok status word.
//
`default_nettype none

module positional_list_store
    import pls_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int CW = $clog2(DEPTH + 1);   // fill and cursor width
    localparam int AW = $clog2(DEPTH);       // slot address width

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INS_RD  = 8'b0000_0010,
        S_INS_WR  = 8'b0000_0100,
        S_DEL_RD  = 8'b0000_1000,
        S_DEL_WR  = 8'b0001_0000,
        S_RD_REQ  = 8'b0010_0000,
        S_RD_EMIT = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    // Sequencer state
    t_state                r_state,  n_state;
    logic [CW-1:0]         r_fill,   n_fill;
    logic [CW-1:0]         r_cur,    n_cur;
    logic [CW-1:0]         r_bound,  n_bound;
    logic [DATA_WIDTH-1:0] r_val,    n_val;
    logic [1:0]            r_status, n_status;

    // Output register
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out,       n_out;

    // RAM ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Shared cursor unit
    logic [CW-1:0]         cur_bound;
    logic                  cur_up;
    logic [CW-1:0]         cur_nxt;
    logic                  cur_hit;
    logic                  nxt_hit;

    // Decode helpers
    logic [8:0]            pos_w;
    logic [8:0]            fill_w;
    logic [7:0]            pos_m1;
    logic [CW-1:0]         pos_idx;
    logic                  is_full;
    logic                  is_empty;
    logic                  out_free;

    pls_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Inserts walk down toward the insert index; deletes and read-out walk up
    // toward the fill count.
    assign cur_up    = !((r_state == S_INS_RD) || (r_state == S_INS_WR));
    assign cur_bound = cur_up ? r_fill : r_bound;

    pls_cursor #(
        .CW (CW)
    ) u_cursor (
        .i_cur     (r_cur),
        .i_bound   (cur_bound),
        .i_up      (cur_up),
        .o_nxt     (cur_nxt),
        .o_hit_cur (cur_hit),
        .o_hit_nxt (nxt_hit)
    );

    assign pos_w    = {1'b0, i_in_word.position};
    assign fill_w   = 9'(r_fill);
    assign pos_m1   = i_in_word.position - 8'd1;
    assign pos_idx  = pos_m1[CW-1:0];
    assign is_full  = (r_fill == CW'(DEPTH));
    assign is_empty = (r_fill == '0);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cur       = r_cur;
        n_bound     = r_bound;
        n_val       = r_val;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;   // drop once taken

        ram_we    = 1'b0;
        ram_waddr = r_cur[AW-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = cur_nxt[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val    = DATA_WIDTH'(i_in_word.value);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (i_in_word.command)
                        CMD_INS_FRONT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_cur   = r_fill;
                                n_bound = '0;
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_INS_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_cur   = r_fill;
                                n_bound = r_fill;
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_INS_AT: begin
                            if ((pos_w == 9'd0) || (pos_w > (fill_w + 9'd1))) begin
                                n_status = ST_BADPOS;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_cur   = r_fill;
                                n_bound = pos_idx;
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_DEL_FRONT: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cur   = '0;
                                n_state = S_DEL_RD;
                            end
                        end
                        CMD_DEL_BACK: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cur   = r_fill - CW'(1);
                                n_state = S_DEL_RD;
                            end
                        end
                        CMD_DEL_AT: begin
                            if ((pos_w == 9'd0) || (pos_w > fill_w)) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_cur   = pos_idx;
                                n_state = S_DEL_RD;
                            end
                        end
                        CMD_READ_ALL: begin
                            if (!is_empty) begin
                                n_cur   = '0;
                                n_state = S_RD_REQ;
                            end
                        end
                        default: begin
                            // unused code: one ok status word, no change
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                if (cur_hit) begin
                    // gap reached the insert index: drop the new word in
                    ram_we    = 1'b1;
                    ram_wdata = r_val;
                    n_fill    = r_fill + CW'(1);
                    n_state   = S_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                // move the lower neighbor up into the gap
                ram_we  = 1'b1;
                n_cur   = cur_nxt;
                n_state = S_INS_RD;
            end

            S_DEL_RD: begin
                if (nxt_hit) begin
                    // cursor on the old tail: the list just got shorter
                    n_fill  = r_fill - CW'(1);
                    n_state = S_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_DEL_WR;
                end
            end

            S_DEL_WR: begin
                // pull the upper neighbor down over the removed entry
                ram_we  = 1'b1;
                n_cur   = cur_nxt;
                n_state = S_DEL_RD;
            end

            S_RD_REQ: begin
                ram_re    = 1'b1;
                ram_raddr = r_cur[AW-1:0];
                n_state   = S_RD_EMIT;
            end

            S_RD_EMIT: begin
                // read data holds until the result register frees up
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = ST_OK;
                    n_out.element     = 32'(ram_rdata);
                    n_out.has_element = 1'b1;
                    n_out.entry_count = 5'(r_fill);
                    n_out.last        = nxt_hit;
                    n_cur             = cur_nxt;
                    n_state           = nxt_hit ? S_IDLE : S_RD_REQ;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.element     = '0;
                    n_out.has_element = 1'b0;
                    n_out.entry_count = 5'(r_fill);
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_bound  <= n_bound;
        r_val    <= n_val;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count above DEPTH");

    a_fill_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
            ((r_fill == $past(r_fill) + CW'(1)) || (r_fill == $past(r_fill) - CW'(1))))
        else $error("fill count moved by more than one");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS_RD) || (r_state == S_INS_WR) || (r_state == S_DEL_RD) ||
         (r_state == S_DEL_WR) || (r_state == S_RD_REQ) || (r_state == S_RD_EMIT))
            |-> (r_cur < CW'(DEPTH)))
        else $error("slot cursor out of range");

    a_element_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.has_element) |-> (r_out.status == ST_OK))
        else $error("list entry word with non-ok status");

    a_change_only_after_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |-> (r_state == S_DONE))
        else $error("fill count changed outside an edit");

endmodule

`default_nettype wire

@@ test/positional_list_store_tb.sv @@
// ============================================================================
// positional_list_store_tb: self-checking bench for the positional list store
// Drives command words through the valid/stall input channel, keeps a shadow
// copy of the list to work out every status and read-out word, and checks
// each result word field by field under several idle and stall patterns.
// ============================================================================
module positional_list_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int LONG_HOLD  = 300;   // receiver hold-off, in cycles
    localparam int TAIL_WAIT  = 64;    // covers the slowest edit after the last result

    // Code 7 is not decoded by the block; it must come back as a plain ok word.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ------------------------------------------------------------------------
    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    positional_list_store #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_in_word    command_words[$];          // words still to be offered
    t_out_word   results_due[$];            // words the block owes, oldest first
    logic [31:0] shadow_slots[LIST_DEPTH];  // list contents in order
    int          shadow_fill  = 0;
    int          mismatches   = 0;

    int send_idle_pct  = 0;   // chance per cycle that the sender offers nothing
    int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    int hold_asks      = 0;   // bumped by the stimulus to request a long hold-off
    int hold_granted   = 0;
    int hold_left      = 0;

    // Entry count as the stimulus sees it; steers positions toward valid ones.
    int plan_fill   = 0;
    bit plan_rising = 1'b1;

    // ------------------------------------------------------------------------
    // Shadow list: edit it and work out the words each command produces
    // ------------------------------------------------------------------------
    function automatic void shadow_insert(input int idx, input logic [31:0] value);
        for (int i = shadow_fill; i > idx; i--)
            shadow_slots[i] = shadow_slots[i - 1];
        shadow_slots[idx] = value;
        shadow_fill++;
    endfunction

    function automatic void shadow_remove(input int idx);
        for (int i = idx; i + 1 < shadow_fill; i++)
            shadow_slots[i] = shadow_slots[i + 1];
        shadow_fill--;
    endfunction

    function automatic void apply_list_command(input t_in_word w);
        t_out_word  r;
        logic [1:0] st;
        int         pos;
        st  = ST_OK;
        r   = '0;
        pos = int'(w.position);
        if (w.command == CMD_READ_ALL) begin
            // Read-out: one word per entry, or a lone empty word.
            if (shadow_fill == 0) begin
                r.last = 1'b1;
                results_due.push_back(r);
            end else begin
                for (int i = 0; i < shadow_fill; i++) begin
                    r.status      = ST_OK;
                    r.element     = shadow_slots[i];
                    r.has_element = 1'b1;
                    r.entry_count = 5'(shadow_fill);
                    r.last        = (i == shadow_fill - 1);
                    results_due.push_back(r);
                end
            end
        end else begin
            case (w.command)
                CMD_INS_FRONT, CMD_INS_BACK: begin
                    if (shadow_fill >= LIST_DEPTH) st = ST_FULL;
                    else shadow_insert((w.command == CMD_INS_FRONT) ? 0 : shadow_fill,
                                       w.value);
                end
                CMD_INS_AT: begin
                    // Position is checked ahead of the full check.
                    if (pos < 1 || pos > shadow_fill + 1) st = ST_BADPOS;
                    else if (shadow_fill >= LIST_DEPTH) st = ST_FULL;
                    else shadow_insert(pos - 1, w.value);
                end
                CMD_DEL_FRONT, CMD_DEL_BACK: begin
                    if (shadow_fill == 0) st = ST_EMPTY;
                    else shadow_remove((w.command == CMD_DEL_FRONT) ? 0 : shadow_fill - 1);
                end
                CMD_DEL_AT: begin
                    // An empty list reports a bad position here, not empty.
                    if (pos < 1 || pos > shadow_fill) st = ST_BADPOS;
                    else shadow_remove(pos - 1);
                end
                default: ;  // unused code: no change, ok status
            endcase
            r.status      = st;
            r.entry_count = 5'(shadow_fill);
            r.last        = 1'b1;
            results_due.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Compare one accepted result word with the oldest awaited word
    // ------------------------------------------------------------------------
    function automatic void check_result(input t_out_word got);
        t_out_word want;
        if (results_due.size() == 0) begin
            $display("%0t: result word with none awaited: expected nothing, got %h",
                     $time, got);
            mismatches++;
        end else begin
            want = results_due.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.element !== want.element) begin
                $display("%0t: element expected %h got %h", $time, want.element, got.element);
                mismatches++;
            end
            if (got.has_element !== want.has_element) begin
                $display("%0t: has_element expected %b got %b",
                         $time, want.has_element, got.has_element);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count expected %0d got %0d",
                         $time, want.entry_count, got.entry_count);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b got %b", $time, want.last, got.last);
                mismatches++;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next word, hold it until accepted, predict on accept
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        bit offering;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            offering = in_valid;
            if (in_valid && !in_stall) begin
                apply_list_command(in_word);
                command_words.delete(0);
                offering = 1'b0;
            end
            // A word still waiting stays put; otherwise pick the next or idle.
            if (!offering) begin
                if (command_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_word  <= command_words[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check accepted result words and drive the receiver stall
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                check_result(out_word);
            // A long hold-off takes priority over the random stall pattern.
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_granted != hold_asks) begin
                hold_granted++;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_word(input logic [2:0] cmd, input logic [31:0] value,
                                       input int pos);
        t_in_word w;
        w.command  = cmd;
        w.value    = value;
        w.position = 8'(pos);
        command_words.push_back(w);
        // Track the count so later positions land inside the list.
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK: if (plan_fill < LIST_DEPTH) plan_fill++;
            CMD_INS_AT:
                if (pos >= 1 && pos <= plan_fill + 1 && plan_fill < LIST_DEPTH) plan_fill++;
            CMD_DEL_FRONT, CMD_DEL_BACK: if (plan_fill > 0) plan_fill--;
            CMD_DEL_AT: if (pos >= 1 && pos <= plan_fill) plan_fill--;
            default: ;
        endcase
    endfunction

    // Mostly well-formed edits that swing the list between empty and full,
    // with read-outs, stray positions and the unused code mixed in.
    function automatic void queue_random_word();
        int pick;
        int kind;
        pick = $urandom_range(99);
        kind = $urandom_range(2);
        // Linger at the ends so full inserts and empty deletes both show up.
        if (plan_fill == LIST_DEPTH && $urandom_range(3) == 0) plan_rising = 1'b0;
        if (plan_fill == 0 && $urandom_range(2) == 0) plan_rising = 1'b1;
        if (pick < 9) begin
            queue_word(CMD_READ_ALL, $urandom, $urandom_range(255));
        end else if (pick < 11) begin
            queue_word(CMD_UNUSED, $urandom, $urandom_range(255));
        end else if (pick < 16) begin
            queue_word($urandom_range(1) ? CMD_INS_AT : CMD_DEL_AT, $urandom,
                       $urandom_range(255));
        end else if ($urandom_range(99) < (plan_rising ? 75 : 25)) begin
            case (kind)
                0: queue_word(CMD_INS_FRONT, $urandom, $urandom_range(255));
                1: queue_word(CMD_INS_BACK, $urandom, $urandom_range(255));
                default: queue_word(CMD_INS_AT, $urandom, $urandom_range(plan_fill + 1, 1));
            endcase
        end else begin
            case (kind)
                0: queue_word(CMD_DEL_FRONT, $urandom, $urandom_range(255));
                1: queue_word(CMD_DEL_BACK, $urandom, $urandom_range(255));
                default: queue_word(CMD_DEL_AT, $urandom,
                                    (plan_fill == 0) ? $urandom_range(2)
                                                     : $urandom_range(plan_fill, 1));
            endcase
        end
    endfunction

    // Hold the sender back until every offered word is in and answered.
    task automatic wait_list_drained();
        @(negedge i_clk);
        while (command_words.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        @(negedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) queue_random_word();
        wait_list_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list cases first, then edits at every position kind.
        @(negedge i_clk);
        queue_word(CMD_READ_ALL,  32'h0,        0);    // read of an empty list
        queue_word(CMD_DEL_FRONT, 32'h0,        0);    // empty
        queue_word(CMD_DEL_BACK,  32'h0,        0);    // empty
        queue_word(CMD_DEL_AT,    32'h0,        1);    // bad position on empty list
        queue_word(CMD_INS_AT,    32'h1234,     0);    // position zero
        queue_word(CMD_INS_AT,    32'h1234,     2);    // one past the end plus one
        queue_word(CMD_INS_AT,    32'h0000_0000, 1);
        queue_word(CMD_INS_FRONT, 32'hFFFF_FFFF, 0);
        queue_word(CMD_INS_BACK,  32'hA5A5_A5A5, 255);
        queue_word(CMD_INS_AT,    32'h5A5A_5A5A, 2);   // into the middle
        queue_word(CMD_INS_AT,    32'h1234_5678, 5);   // append by position
        queue_word(CMD_INS_AT,    32'hDEAD_BEEF, 255); // far past the end
        queue_word(CMD_DEL_AT,    32'h0,        0);
        queue_word(CMD_DEL_AT,    32'h0,        6);    // one past the end
        queue_word(CMD_UNUSED,    32'hFFFF_FFFF, 255);
        queue_word(CMD_READ_ALL,  32'h0,        0);
        queue_word(CMD_DEL_AT,    32'h0,        3);
        queue_word(CMD_DEL_FRONT, 32'h0,        0);
        queue_word(CMD_DEL_BACK,  32'h0,        0);
        queue_word(CMD_DEL_AT,    32'h0,        2);    // last entry by position
        queue_word(CMD_DEL_AT,    32'h0,        1);
        queue_word(CMD_READ_ALL,  32'h0,        0);
        wait_list_drained();

        run_phase(0,  0,  100);   // back to back
        run_phase(81, 0,  90);    // sparse sender
        run_phase(0,  81, 90);    // heavy receiver stall

        // Pressure: hold the receiver off while the sender keeps offering,
        // so the result register fills and the input channel backs up.
        @(negedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks++;
        repeat (40) queue_random_word();
        wait_list_drained();

        run_phase(26, 26, 90);    // both sides gapped

        // Let any stray word surface before the verdict.
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("positional_list_store_tb: clean");
        else
            $display("positional_list_store_tb: errors");
        $finish;
    end

    // Drop the run if the block hangs.
    initial begin : watchdog
        #5_000_000;
        $display("positional_list_store_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pls_pkg.sv
rtl/pls_ram.sv
rtl/pls_cursor.sv
rtl/positional_list_store.sv
test/positional_list_store_tb.sv
